FILE: rtl/dss_pkg.sv
// ============================================================================
// dss_pkg
// Types, codes and helpers shared by the disk sweep scheduler modules.
// ============================================================================
package dss_pkg;

    localparam int CYL_W      = 16;
    localparam int ARRIVAL_W  = 6;
    localparam int DIST_W     = 22;
    localparam int DIST_ACC_W = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MODE_W     = 2;

    localparam logic [MODE_W-1:0] MODE_FCFS  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CSCAN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_LIMIT = 2'd2;

    typedef struct packed {
        logic [CYL_W-1:0] request_cylinder;
        logic             last_request;
    } request_t;

    typedef struct packed {
        logic [CYL_W-1:0]     served_cylinder;
        logic [ARRIVAL_W-1:0] arrival_index;
        logic [DIST_W-1:0]    distance_so_far;
        logic                 last_served;
        logic                 overflowed;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic load;
        logic serve_init;
        logic pass_clear;
        logic issue;
        logic emit;
        logic switch_back;
        logic batch_done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic issue_last;
        logic best_found;
        logic final_emit;
        logic can_turn;
    } dp_status_t;

    function automatic logic [CYL_W-1:0] clamp_cyl(input logic [CYL_W-1:0] c,
                                                   input logic [CYL_W-1:0] lim);
        return (c > lim) ? lim : c;
    endfunction

endpackage

FILE: rtl/dss_ram.sv
// ============================================================================
// dss_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module dss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/dss_datapath.sv
// ============================================================================
// dss_datapath
// Configuration registers, request store, compare pass and result register.
// ============================================================================
module dss_datapath #(
    parameter int MAX_REQUESTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dss_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  dss_pkg::request_t                   request,
    input  dss_pkg::ctrl_cmd_t                  cmd,
    output dss_pkg::dp_status_t                 status,
    output logic                                result_valid,
    output dss_pkg::result_t                    result
);
    import dss_pkg::*;

    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REQUESTS);

    logic [MODE_W-1:0]       mode_reg;
    logic [CYL_W-1:0]        start_head_reg;
    logic [CYL_W-1:0]        disk_limit_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    drop_reg;
    logic [MAX_REQUESTS-1:0] marks_reg;
    logic                    phase_up_reg;
    logic [CYL_W-1:0]        h0_reg;
    logic [CYL_W-1:0]        head_reg;
    logic [DIST_ACC_W-1:0]   dist_reg;
    logic [IDX_W-1:0]        scan_idx_reg;
    logic                    cmp_valid_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic                    best_found_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic [CYL_W-1:0]        best_cyl_reg;
    logic [CNT_W-1:0]        served_cnt_reg;
    logic                    result_valid_reg;
    result_t                 result_reg;

    logic                    ram_we;
    logic [CYL_W-1:0]        ram_rdata;
    logic [CYL_W-1:0]        load_cyl;
    logic [CYL_W-1:0]        cand_cyl;
    logic                    sweep_mode;
    logic                    want_min;
    logic [CYL_W-1:0]        floor_cyl;
    logic                    qualify;
    logic                    better;
    logic [CYL_W-1:0]        abs_move;
    logic [CYL_W-1:0]        lim_minus_h0;
    logic [CYL_W:0]          sweep_dist;
    logic [DIST_ACC_W-1:0]   dist_next;

    assign load_cyl = clamp_cyl(request.request_cylinder, disk_limit_reg);
    assign ram_we   = cmd.load && (count_reg < MAX_CNT);

    dss_ram #(
        .WIDTH (CYL_W),
        .DEPTH (MAX_REQUESTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (load_cyl),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    // Candidate selection on the entry that the store returns this cycle.
    // Strict compares keep the lowest index among equal cylinders.
    always_comb
    begin
        sweep_mode = (mode_reg == MODE_SCAN) || (mode_reg == MODE_CSCAN);
        want_min   = phase_up_reg || (mode_reg == MODE_CSCAN);
        floor_cyl  = phase_up_reg ? h0_reg : '0;
        cand_cyl   = clamp_cyl(ram_rdata, disk_limit_reg);
        if (sweep_mode)
        begin
            qualify = !marks_reg[cmp_idx_reg] && (cand_cyl >= floor_cyl);
            better  = !best_found_reg ||
                      (want_min ? (cand_cyl < best_cyl_reg) : (cand_cyl > best_cyl_reg));
        end
        else
        begin
            qualify = !marks_reg[cmp_idx_reg];
            better  = !best_found_reg;
        end
    end

    // Head movement for the request about to be served.
    always_comb
    begin
        abs_move     = (best_cyl_reg >= head_reg) ? (best_cyl_reg - head_reg)
                                                  : (head_reg - best_cyl_reg);
        lim_minus_h0 = disk_limit_reg - h0_reg;
        if (phase_up_reg)
        begin
            sweep_dist = {1'b0, best_cyl_reg - h0_reg};
        end
        else if (mode_reg == MODE_CSCAN)
        begin
            sweep_dist = {1'b0, lim_minus_h0} + {1'b0, best_cyl_reg};
        end
        else
        begin
            sweep_dist = {1'b0, lim_minus_h0} + {1'b0, disk_limit_reg - best_cyl_reg};
        end
        if (sweep_mode)
        begin
            dist_next = DIST_ACC_W'(sweep_dist);
        end
        else
        begin
            dist_next = dist_reg + DIST_ACC_W'(abs_move);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_SCAN;
            start_head_reg   <= '0;
            disk_limit_reg   <= '1;
            count_reg        <= '0;
            drop_reg         <= 1'b0;
            marks_reg        <= '0;
            phase_up_reg     <= 1'b1;
            head_reg         <= '0;
            dist_reg         <= '0;
            cmp_valid_reg    <= 1'b0;
            best_found_reg   <= 1'b0;
            served_cnt_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE:       mode_reg       <= cfg_data[MODE_W-1:0];
                    CFG_START_HEAD: start_head_reg <= cfg_data[CYL_W-1:0];
                    CFG_DISK_LIMIT: disk_limit_reg <= cfg_data[CYL_W-1:0];
                    default:        ;
                endcase
            end

            if (cmd.load)
            begin
                if (count_reg < MAX_CNT)
                begin
                    marks_reg[count_reg[IDX_W-1:0]] <= 1'b0;
                    count_reg                       <= count_reg + 1'b1;
                end
                else
                begin
                    drop_reg <= 1'b1;
                end
            end

            if (cmd.serve_init)
            begin
                head_reg       <= clamp_cyl(start_head_reg, disk_limit_reg);
                dist_reg       <= '0;
                phase_up_reg   <= 1'b1;
                served_cnt_reg <= '0;
            end

            cmp_valid_reg <= cmd.issue;
            if (cmd.pass_clear)
            begin
                best_found_reg <= 1'b0;
            end
            else if (cmp_valid_reg && qualify && better)
            begin
                best_found_reg <= 1'b1;
            end

            result_valid_reg <= cmd.emit;
            if (cmd.emit)
            begin
                marks_reg[best_idx_reg] <= 1'b1;
                head_reg                <= best_cyl_reg;
                dist_reg                <= dist_next;
                served_cnt_reg          <= served_cnt_reg + 1'b1;
            end

            if (cmd.switch_back)
            begin
                phase_up_reg <= 1'b0;
            end

            if (cmd.batch_done)
            begin
                count_reg <= '0;
                marks_reg <= '0;
                drop_reg  <= 1'b0;
                dist_reg  <= '0;
            end
        end
    end

    // Payload registers without reset.
    always_ff @(posedge clk)
    begin
        if (cmd.serve_init)
        begin
            h0_reg <= clamp_cyl(start_head_reg, disk_limit_reg);
        end
        if (cmd.pass_clear)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.issue)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        cmp_idx_reg <= scan_idx_reg;
        if (!cmd.pass_clear && cmp_valid_reg && qualify && better)
        begin
            best_idx_reg <= cmp_idx_reg;
            best_cyl_reg <= cand_cyl;
        end
        if (cmd.emit)
        begin
            result_reg.served_cylinder <= best_cyl_reg;
            result_reg.arrival_index   <= ARRIVAL_W'(best_idx_reg);
            result_reg.distance_so_far <= dist_next[DIST_W-1:0];
            result_reg.last_served     <= status.final_emit;
            result_reg.overflowed      <= drop_reg;
        end
    end

    assign status.issue_last = (CNT_W'(scan_idx_reg) == (count_reg - 1'b1));
    assign status.best_found = best_found_reg;
    assign status.final_emit = ((served_cnt_reg + 1'b1) == count_reg);
    assign status.can_turn   = sweep_mode && phase_up_reg;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/dss_controller.sv
// ============================================================================
// dss_controller
// Sequencer for loading, compare passes, sweep turn and result emission.
// ============================================================================
module dss_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                last_request,
    input  dss_pkg::dp_status_t status,
    output dss_pkg::ctrl_cmd_t  cmd,
    output logic                busy
);
    import dss_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_request)
                    begin
                        cmd.serve_init = 1'b1;
                        cmd.pass_clear = 1'b1;
                        state_next     = ST_PASS;
                    end
                end
            end
            ST_PASS:
            begin
                cmd.issue = 1'b1;
                if (status.issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (status.best_found)
                begin
                    cmd.emit = 1'b1;
                    if (status.final_emit)
                    begin
                        cmd.batch_done = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        cmd.pass_clear = 1'b1;
                        state_next     = ST_PASS;
                    end
                end
                else if (status.can_turn)
                begin
                    // Nothing left at or above the start head: sweep back.
                    cmd.switch_back = 1'b1;
                    cmd.pass_clear  = 1'b1;
                    state_next      = ST_PASS;
                end
                else
                begin
                    cmd.batch_done = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/disk_sweep_scheduler_unit.sv
// ============================================================================
// disk_sweep_scheduler_unit
// Batch disk request scheduler: first come first served, scan, circular scan.
// ============================================================================
// Usage: write mode, start_head and disk_limit through cfg_we/cfg_index/
// cfg_data while the block is idle. Each request is taken when start is high
// and busy is low, so requests load back to back, and requests beyond
// MAX_REQUESTS are dropped and flagged on every result of the batch.
// The request with last_request set closes the batch and raises busy.
// Service then runs one compare pass over the n stored requests for each
// result: a pass reads the request store once per entry, and a scan batch
// that turns takes one extra pass.
// Each result appears on result for exactly one cycle with result_valid
// high; the receiver cannot stall, so no result is ever held back.
// busy is low again in the cycle that carries the final result.
// Reset returns the block to idle with an empty batch, the head at cylinder
// zero and the configuration at its defaults; no clearing pass is needed.
// ============================================================================
module disk_sweep_scheduler_unit #(
    parameter int MAX_REQUESTS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  dss_pkg::request_t              request,
    output logic                           result_valid,
    output dss_pkg::result_t               result,
    input  logic                           cfg_we,
    input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dss_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    dss_controller u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .last_request (request.last_request),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy)
    );

    dss_datapath #(
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .request      (request),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
